// ===== rtl/core/cda_pkg.sv =====
// Shared constants, functions and calendar tables for the calendar date arithmetic block.
package cda_pkg;

  // Field widths of the request and result transactions.
  localparam int OP_W    = 2;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 20;
  localparam int DIFF_W  = 23;
  localparam int ORDER_W = 2;

  // Internal widths: candidate year, absolute day number, day-of-year remainder.
  localparam int YW     = 15;
  localparam int DW     = 26;
  localparam int DBY_W  = 24;
  localparam int REST_W = 9;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 15;
  localparam int PROD_W  = 32;

  // Division by 100 as a multiplication by a reciprocal (exact below 43690).
  localparam logic [MUL_B_W-1:0] RECIP_100   = 15'd5243;
  localparam int                 RECIP_SHIFT = 19;
  localparam int                 C100_W      = 8;
  localparam int                 C400_W      = 6;
  localparam logic [MUL_B_W-1:0] DAYS_365    = 15'd365;

  // Year estimate: (n >> 6) * 22967 >> 17 never exceeds n / 365.2425.
  localparam int                 EST_SHIFT        = 6;
  localparam logic [MUL_B_W-1:0] YEAR_RECIP       = 15'd22967;
  localparam int                 YEAR_RECIP_SHIFT = 17;

  localparam int MAX_YEAR_DEFAULT = 9999;
  localparam int MONTHS_PER_YEAR  = 12;
  localparam int DIFF_MAX         = 4194303;

  // Operation codes; bit one set selects the difference operation.
  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 2'd1;
  localparam logic [OP_W-1:0] OP_DIFF = 2'd2;
  localparam int              OP_DIFF_BIT = 1;

  // Order codes.
  localparam logic [ORDER_W-1:0] ORDER_EARLIER = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_LATER   = 2'd2;

  // Status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Days from 1 January of year 0 to 1 January of year y, for elaboration-time constants.
  function automatic int days_before_year_c(int y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  // Month numbers outside 1 to 12 are pulled to the nearest end.
  function automatic logic [MONTH_W-1:0] clamp_month(logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] r;
    if (m == 4'd0) begin
      r = 4'd1;
    end else if (m > 4'(MONTHS_PER_YEAR)) begin
      r = 4'(MONTHS_PER_YEAR);
    end else begin
      r = m;
    end
    return r;
  endfunction

  // Days in a common year before the first of month m.
  function automatic logic [REST_W-1:0] days_before_month(logic [MONTH_W-1:0] m);
    logic [REST_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of month m; February gains a day in a leap year.
  function automatic logic [DAY_W-1:0] month_length(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/calendar_date_arithmetic.sv =====
// Top level: Gregorian date add, subtract and difference on one shared multiplier.
// An in-range add or subtract runs a year search (the day-before-year steps on the shared
// multiplier for each candidate year, two to four candidates) and then a month walk
// (one month per cycle). One transaction is in flight at a time; a new one is taken in
// the cycle after the result moves to the output register. Synchronous reset clears the
// sequencer and out_valid.
module calendar_date_arithmetic #(
  parameter int MAX_YEAR = cda_pkg::MAX_YEAR_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cda_pkg::OP_W-1:0]           operation,
  input  logic [cda_pkg::YEAR_W-1:0]         year,
  input  logic [cda_pkg::MONTH_W-1:0]        month,
  input  logic [cda_pkg::DAY_W-1:0]          day,
  input  logic [cda_pkg::COUNT_W-1:0]        day_count,
  input  logic [cda_pkg::YEAR_W-1:0]         other_year,
  input  logic [cda_pkg::MONTH_W-1:0]        other_month,
  input  logic [cda_pkg::DAY_W-1:0]          other_day,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cda_pkg::YEAR_W-1:0]         result_year,
  output logic [cda_pkg::MONTH_W-1:0]        result_month,
  output logic [cda_pkg::DAY_W-1:0]          result_day,
  output logic signed [cda_pkg::DIFF_W-1:0]  day_difference,
  output logic [cda_pkg::ORDER_W-1:0]        order,
  output logic                               status
);

  localparam int DW     = cda_pkg::DW;
  localparam int YW     = cda_pkg::YW;
  localparam int DBY_W  = cda_pkg::DBY_W;
  localparam int REST_W = cda_pkg::REST_W;

  // Day-number window of valid result dates.
  localparam logic signed [DW-1:0] DAY_FIRST = DW'(cda_pkg::days_before_year_c(1));
  localparam logic signed [DW-1:0] DAYS_END  = DW'(cda_pkg::days_before_year_c(MAX_YEAR + 1));
  localparam logic signed [DW-1:0] DIFF_HI   = DW'(cda_pkg::DIFF_MAX);
  localparam logic signed [DW-1:0] DIFF_LO   = -DIFF_HI;
  localparam logic [16:0]          MAX_YEAR_C = 17'(MAX_YEAR);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_DBY_A = 12'b0000_0000_0010,
    S_DBY_B = 12'b0000_0000_0100,
    S_DBY_C = 12'b0000_0000_1000,
    S_DBY_D = 12'b0000_0001_0000,
    S_POST  = 12'b0000_0010_0000,
    S_MOVE  = 12'b0000_0100_0000,
    S_RANGE = 12'b0000_1000_0000,
    S_EST   = 12'b0001_0000_0000,
    S_MONTH = 12'b0010_0000_0000,
    S_DIFF  = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  // What the day-before-year result is used for.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_BASE   = 2'd2,
    PH_STEP   = 2'd3
  } phase_t;

  state_t state;
  phase_t phase;

  // Latched request.
  logic [cda_pkg::OP_W-1:0]    op;
  logic [cda_pkg::MONTH_W-1:0] first_month;
  logic [cda_pkg::DAY_W-1:0]   first_day;
  logic [cda_pkg::COUNT_W-1:0] count;
  logic [cda_pkg::YEAR_W-1:0]  second_year;
  logic [cda_pkg::MONTH_W-1:0] second_month;
  logic [cda_pkg::DAY_W-1:0]   second_day;
  logic                        year_bad;

  // Shared multiplier and day-before-year datapath.
  logic [cda_pkg::MUL_A_W-1:0] mul_a;
  logic [cda_pkg::MUL_B_W-1:0] mul_b;
  logic [cda_pkg::PROD_W-1:0]  prod;
  logic [YW-1:0]               cand_year;
  logic [cda_pkg::C100_W-1:0]  c100;
  logic [cda_pkg::C400_W-1:0]  c400;
  logic [DBY_W-1:0]            dby;
  logic                        leap;

  // Day numbers and year/month search state.
  logic signed [DW-1:0]        first_num;
  logic signed [DW-1:0]        second_num;
  logic signed [DW-1:0]        day_num;
  logic [YW-1:0]               cur_year;
  logic [DBY_W-1:0]            cur_dby;
  logic                        cur_leap;
  logic [REST_W-1:0]           rest;
  logic [cda_pkg::MONTH_W-1:0] mon;

  // Finished result waiting for the output register.
  logic [cda_pkg::YEAR_W-1:0]        res_year;
  logic [cda_pkg::MONTH_W-1:0]       res_month;
  logic [cda_pkg::DAY_W-1:0]         res_day;
  logic signed [cda_pkg::DIFF_W-1:0] res_diff;
  logic [cda_pkg::ORDER_W-1:0]       res_order;
  logic                              res_status;

  // Combinational helpers.
  logic [cda_pkg::MONTH_W-1:0] sel_month;
  logic [cda_pkg::DAY_W-1:0]   sel_day;
  logic                        late_month;
  logic signed [DW-1:0]        date_num_next;
  logic signed [DW-1:0]        dby_ext;
  logic signed [DW-1:0]        cur_dby_ext;
  logic signed [DW-1:0]        count_ext;
  logic signed [DW-1:0]        diff_full;
  logic [YW-1:0]               est_year;
  logic [cda_pkg::DAY_W-1:0]   mon_len;
  logic                        year_ok_first;
  logic                        year_ok_second;

  assign in_ready = (state == S_IDLE);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      S_DBY_A: begin
        mul_a = cda_pkg::MUL_A_W'(cand_year) + cda_pkg::MUL_A_W'(99);
        mul_b = cda_pkg::RECIP_100;
      end
      S_DBY_B: begin
        mul_a = (cda_pkg::MUL_A_W'(cand_year) + cda_pkg::MUL_A_W'(399)) >> 2;
        mul_b = cda_pkg::RECIP_100;
      end
      S_DBY_C: begin
        mul_a = cda_pkg::MUL_A_W'(cand_year);
        mul_b = cda_pkg::DAYS_365;
      end
      S_RANGE: begin
        mul_a = day_num[cda_pkg::EST_SHIFT +: cda_pkg::MUL_A_W];
        mul_b = cda_pkg::YEAR_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Day number of the selected date from its day-before-year value.
  always_comb begin
    sel_month     = cda_pkg::clamp_month((phase == PH_SECOND) ? second_month : first_month);
    sel_day       = (phase == PH_SECOND) ? second_day : first_day;
    late_month    = (sel_month > 4'd2) && leap;
    date_num_next = signed'(DW'(dby)) + signed'(DW'(cda_pkg::days_before_month(sel_month)))
                  + signed'(DW'(late_month)) + signed'(DW'(sel_day)) - DW'(1);
  end

  // Miscellaneous conversions and comparisons.
  always_comb begin
    dby_ext        = signed'(DW'(dby));
    cur_dby_ext    = signed'(DW'(cur_dby));
    count_ext      = signed'(DW'(count));
    diff_full      = first_num - second_num;
    est_year       = prod[cda_pkg::YEAR_RECIP_SHIFT +: YW];
    mon_len        = cda_pkg::month_length(mon, cur_leap);
    year_ok_first  = (year != '0) && ({3'b000, year} <= MAX_YEAR_C);
    year_ok_second = (other_year != '0) && ({3'b000, other_year} <= MAX_YEAR_C);
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_FIRST;
      out_valid <= 1'b0;
    end else begin
      // A taken result empties the output register unless a new one is loaded now.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        // Wait for a request transaction and latch it.
        S_IDLE: begin
          if (in_valid) begin
            op           <= operation;
            first_month  <= month;
            first_day    <= day;
            count        <= day_count;
            second_year  <= other_year;
            second_month <= other_month;
            second_day   <= other_day;
            year_bad     <= !year_ok_first || !year_ok_second;
            cand_year    <= YW'(year);
            phase        <= PH_FIRST;
            state        <= S_DBY_A;
          end
        end
        // Day-before-year: three products, then the sum and leap test.
        S_DBY_A: begin
          state <= S_DBY_B;
        end
        S_DBY_B: begin
          c100  <= prod[cda_pkg::RECIP_SHIFT +: cda_pkg::C100_W];
          state <= S_DBY_C;
        end
        S_DBY_C: begin
          c400  <= prod[cda_pkg::RECIP_SHIFT +: cda_pkg::C400_W];
          state <= S_DBY_D;
        end
        S_DBY_D: begin
          dby   <= DBY_W'(prod) + DBY_W'((cand_year + YW'(3)) >> 2)
                 - DBY_W'(c100) + DBY_W'(c400);
          leap  <= (cand_year[1:0] == 2'b00)
                && ((YW'(c100) * YW'(100) != cand_year) || (YW'(c400) * YW'(400) == cand_year));
          state <= S_POST;
        end
        // Use the result according to the phase.
        S_POST: begin
          case (phase)
            PH_FIRST: begin
              first_num <= date_num_next;
              if (op[cda_pkg::OP_DIFF_BIT]) begin
                cand_year <= YW'(second_year);
                phase     <= PH_SECOND;
                state     <= S_DBY_A;
              end else begin
                state <= S_MOVE;
              end
            end
            PH_SECOND: begin
              second_num <= date_num_next;
              state      <= S_DIFF;
            end
            default: begin
              if ((phase == PH_BASE) || (dby_ext <= day_num)) begin
                cur_year  <= cand_year;
                cur_dby   <= dby;
                cur_leap  <= leap;
                cand_year <= cand_year + YW'(1);
                phase     <= PH_STEP;
                state     <= S_DBY_A;
              end else begin
                rest  <= REST_W'(day_num - cur_dby_ext);
                mon   <= 4'd1;
                state <= S_MONTH;
              end
            end
          endcase
        end
        // Move the first date by the day count.
        S_MOVE: begin
          day_num <= (op == cda_pkg::OP_SUB) ? first_num - count_ext : first_num + count_ext;
          state   <= S_RANGE;
        end
        // Reject results outside the valid years; otherwise start the year estimate.
        S_RANGE: begin
          if ((day_num < DAY_FIRST) || (day_num >= DAYS_END)) begin
            res_year   <= '0;
            res_month  <= '0;
            res_day    <= '0;
            res_diff   <= '0;
            res_order  <= cda_pkg::ORDER_EARLIER;
            res_status <= cda_pkg::STATUS_RANGE;
            state      <= S_DONE;
          end else begin
            state <= S_EST;
          end
        end
        // The estimate is at most one above the true year; start one below it.
        S_EST: begin
          cand_year <= (est_year == '0) ? '0 : est_year - YW'(1);
          phase     <= PH_BASE;
          state     <= S_DBY_A;
        end
        // Walk the months of the found year, one per cycle.
        S_MONTH: begin
          if ((REST_W'(mon_len) > rest) || (mon == 4'(cda_pkg::MONTHS_PER_YEAR))) begin
            res_year   <= cur_year[cda_pkg::YEAR_W-1:0];
            res_month  <= mon;
            res_day    <= cda_pkg::DAY_W'(rest + REST_W'(1));
            res_diff   <= '0;
            res_order  <= cda_pkg::ORDER_EARLIER;
            res_status <= cda_pkg::STATUS_OK;
            state      <= S_DONE;
          end else begin
            rest <= rest - REST_W'(mon_len);
            mon  <= mon + 4'd1;
          end
        end
        // Signed difference with saturation, and the order of the two dates.
        S_DIFF: begin
          if (diff_full > DIFF_HI) begin
            res_diff <= cda_pkg::DIFF_W'(DIFF_HI);
          end else if (diff_full < DIFF_LO) begin
            res_diff <= cda_pkg::DIFF_W'(DIFF_LO);
          end else begin
            res_diff <= cda_pkg::DIFF_W'(diff_full);
          end
          if (diff_full < 0) begin
            res_order <= cda_pkg::ORDER_EARLIER;
          end else if (diff_full == 0) begin
            res_order <= cda_pkg::ORDER_EQUAL;
          end else begin
            res_order <= cda_pkg::ORDER_LATER;
          end
          res_year   <= '0;
          res_month  <= '0;
          res_day    <= '0;
          res_status <= year_bad ? cda_pkg::STATUS_RANGE : cda_pkg::STATUS_OK;
          state      <= S_DONE;
        end
        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (!out_valid || out_ready) begin
            result_year    <= res_year;
            result_month   <= res_month;
            result_day     <= res_day;
            day_difference <= res_diff;
            order          <= res_order;
            status         <= res_status;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/cda_checker.sv =====
// Port-level checker for the calendar date arithmetic block, with its bind statement.
module cda_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [cda_pkg::YEAR_W-1:0]         result_year,
  input logic [cda_pkg::MONTH_W-1:0]        result_month,
  input logic [cda_pkg::DAY_W-1:0]          result_day,
  input logic signed [cda_pkg::DIFF_W-1:0]  day_difference,
  input logic [cda_pkg::ORDER_W-1:0]        order,
  input logic                               status
);

  // A result transaction that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_year) && $stable(result_month)
      && $stable(result_day) && $stable(day_difference) && $stable(order) && $stable(status))
    else $error("result changed while stalled");

  // Only one request is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // A difference result carries no date, and a date result carries no difference.
  a_fields_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && (day_difference != '0 || order != cda_pkg::ORDER_EARLIER)
      |-> result_year == '0 && result_month == '0 && result_day == '0)
    else $error("date and difference fields both set");

  // A produced date is a real calendar position.
  a_date_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_month != '0
      |-> result_day != '0 && result_month <= 4'd12 && status == cda_pkg::STATUS_OK)
    else $error("result date out of shape");

  // Equal order goes with a zero difference.
  a_equal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && order == cda_pkg::ORDER_EQUAL |-> day_difference == '0)
    else $error("equal order with nonzero difference");

endmodule

bind calendar_date_arithmetic cda_checker u_cda_checker (.*);
